@@ src/taik_pkg.sv @@
`default_nettype none
package taik_pkg;

    localparam int JOINT_COUNT = 9;
    localparam int JOINT_W     = 18;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REACH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOFF  = 3'd4;

    localparam logic [CFG_W-1:0] RST_LOWER = 16'd14207;
    localparam logic [CFG_W-1:0] RST_UPPER = 16'd15881;
    localparam logic [CFG_W-1:0] RST_BASE  = 16'd10660;
    localparam logic [CFG_W-1:0] RST_REACH = 16'd6975;
    localparam logic [CFG_W-1:0] RST_HOFF  = 16'd7455;

    localparam logic signed [31:0] DEG90    = 32'sd94371840;
    localparam logic signed [31:0] DEG180   = 32'sd188743680;
    localparam logic signed [31:0] K_3P8    = 32'sd3984589;
    localparam logic signed [31:0] K_176P11 = 32'sd184664719;
    localparam logic signed [31:0] K_48P39  = 32'sd50740593;
    localparam logic signed [31:0] K_44P55  = 32'sd46714061;

    localparam int ARC_STEPS = 24;
    localparam logic [26:0] ARC_TABLE [ARC_STEPS] = '{
        27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058,
        27'd1876857, 27'd938658, 27'd469357, 27'd234682, 27'd117342,
        27'd58671, 27'd29335, 27'd14668, 27'd7334, 27'd3667, 27'd1833,
        27'd917, 27'd458, 27'd229, 27'd115, 27'd57, 27'd29, 27'd14, 27'd7
    };

    typedef logic signed [JOINT_W-1:0] t_joint;

    function automatic t_joint to_q8(input logic signed [31:0] v);
        logic signed [32:0] s;
        logic signed [20:0] r;
        s = {v[31], v} + 33'sd2048;
        r = s[32:12];
        if (r > 21'sd92160) begin
            to_q8 = 18'sd92160;
        end else if (r < -21'sd92160) begin
            to_q8 = -18'sd92160;
        end else begin
            to_q8 = r[JOINT_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ src/taik_if.sv @@
`default_nettype none
interface taik_target_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] target_x;
    logic signed [16:0] target_y;
    logic signed [16:0] target_z;
    modport source (output valid, output target_x, output target_y, output target_z,
                    input ready);
    modport sink (input valid, input target_x, input target_y, input target_z,
                  output ready);
endinterface

interface taik_joint_if;
    logic              valid;
    logic              ready;
    logic              ik_ok;
    taik_pkg::t_joint  joint_one;
    taik_pkg::t_joint  joint_two;
    taik_pkg::t_joint  joint_three;
    taik_pkg::t_joint  joint_four;
    taik_pkg::t_joint  joint_five;
    taik_pkg::t_joint  joint_six;
    taik_pkg::t_joint  joint_seven;
    taik_pkg::t_joint  joint_eight;
    taik_pkg::t_joint  joint_nine;
    modport source (output valid, output ik_ok, output joint_one, output joint_two,
                    output joint_three, output joint_four, output joint_five,
                    output joint_six, output joint_seven, output joint_eight,
                    output joint_nine, input ready);
    modport sink (input valid, input ik_ok, input joint_one, input joint_two,
                  input joint_three, input joint_four, input joint_five,
                  input joint_six, input joint_seven, input joint_eight,
                  input joint_nine, output ready);
endinterface
`default_nettype wire

@@ src/taik_sqrt.sv @@
`default_nettype none
module taik_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_value,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic        r_busy;
    logic        r_done;
    logic [63:0] r_rem;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= i_value;
                r_res  <= 64'd0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end else if (r_busy) begin
                if (r_rem >= w_trial) begin
                    r_rem <= r_rem - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == 64'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule
`default_nettype wire

@@ src/taik_cordic.sv @@
`default_nettype none
module taik_cordic (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_x,
    input  wire logic [31:0] i_y,
    output logic             o_done,
    output logic signed [31:0] o_angle
);

    logic                r_busy;
    logic                r_done;
    logic [4:0]          r_i;
    logic signed [33:0]  r_x;
    logic signed [33:0]  r_y;
    logic signed [31:0]  r_z;
    logic signed [31:0]  r_angle;
    logic signed [33:0]  w_xs;
    logic signed [33:0]  w_ys;
    logic signed [31:0]  w_arc;
    logic signed [31:0]  w_z;

    assign w_xs  = r_x >>> r_i;
    assign w_ys  = r_y >>> r_i;
    assign w_arc = $signed({5'b0, taik_pkg::ARC_TABLE[r_i]});
    assign w_z   = r_y[33] ? (r_z - w_arc) : (r_z + w_arc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_y == 32'd0) begin
                    r_angle <= 32'sd0;
                    r_done  <= 1'b1;
                end else if (i_x == 32'd0) begin
                    r_angle <= taik_pkg::DEG90;
                    r_done  <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_i    <= 5'd0;
                    r_x    <= $signed({2'b0, i_x});
                    r_y    <= $signed({2'b0, i_y});
                    r_z    <= 32'sd0;
                end
            end else if (r_busy) begin
                if (r_y[33]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                end
                r_z <= w_z;
                r_i <= r_i + 5'd1;
                if (r_i == 5'(taik_pkg::ARC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (w_z < 32'sd0) begin
                        r_angle <= 32'sd0;
                    end else if (w_z > taik_pkg::DEG90) begin
                        r_angle <= taik_pkg::DEG90;
                    end else begin
                        r_angle <= w_z;
                    end
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

endmodule
`default_nettype wire

@@ src/taik_div.sv @@
`default_nettype none
module taik_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [51:0] i_num,
    input  wire logic [50:0] i_den,
    output logic             o_done,
    output logic             o_ok,
    output logic [30:0]      o_quot
);

    logic        r_busy;
    logic        r_done;
    logic        r_ok;
    logic [4:0]  r_cnt;
    logic [51:0] r_rem;
    logic [50:0] r_den;
    logic [30:0] r_quot;
    logic [51:0] w_sh;

    assign w_sh = {r_rem[50:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quot <= 31'd0;
                r_cnt  <= 5'd0;
                if ((i_den == 51'd0) || (i_num > {1'b0, i_den})) begin
                    r_ok   <= 1'b0;
                    r_done <= 1'b1;
                end else if (i_num == {1'b0, i_den}) begin
                    r_ok   <= 1'b1;
                    r_quot <= 31'h4000_0000;
                    r_done <= 1'b1;
                end else begin
                    r_ok   <= 1'b1;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem  <= w_sh - {1'b0, r_den};
                    r_quot <= {r_quot[29:0], 1'b1};
                end else begin
                    r_rem  <= w_sh;
                    r_quot <= {r_quot[29:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd29) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_ok   = r_ok;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

@@ src/three_axis_arm_inverse_kinematics.sv @@
// A reachable target runs through four square roots, four CORDIC passes and two divisions in
// turn; the run is shorter when the target is found unreachable or an angle needs no CORDIC
// pass. No new target is taken until the result has moved on and the sequencer is idle again.
// Reset: configuration returns to its defaults, held joints clear to zero, output is empty.
`default_nettype none
module three_axis_arm_inverse_kinematics #(
    parameter int JOINT_COUNT = taik_pkg::JOINT_COUNT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [taik_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [taik_pkg::CFG_W-1:0]      i_cfg_data,
    taik_target_if.sink                          i_target,
    taik_joint_if.source                         o_joint
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_ROT_GO = 5'd1;
    localparam logic [4:0] S_ROT_WT = 5'd2;
    localparam logic [4:0] S_SQX    = 5'd3;
    localparam logic [4:0] S_SQY    = 5'd4;
    localparam logic [4:0] S_R_GO   = 5'd5;
    localparam logic [4:0] S_R_WT   = 5'd6;
    localparam logic [4:0] S_SQAX   = 5'd7;
    localparam logic [4:0] S_SQAZ   = 5'd8;
    localparam logic [4:0] S_D2     = 5'd9;
    localparam logic [4:0] S_D_GO   = 5'd10;
    localparam logic [4:0] S_D_WT   = 5'd11;
    localparam logic [4:0] S_PHI_GO = 5'd12;
    localparam logic [4:0] S_PHI_WT = 5'd13;
    localparam logic [4:0] S_UU     = 5'd14;
    localparam logic [4:0] S_LL     = 5'd15;
    localparam logic [4:0] S_UD     = 5'd16;
    localparam logic [4:0] S_LD     = 5'd17;
    localparam logic [4:0] S_C1_GO  = 5'd18;
    localparam logic [4:0] S_C1_WT  = 5'd19;
    localparam logic [4:0] S_C2_GO  = 5'd20;
    localparam logic [4:0] S_C2_WT  = 5'd21;
    localparam logic [4:0] S_MM     = 5'd22;
    localparam logic [4:0] S_S_GO   = 5'd23;
    localparam logic [4:0] S_S_WT   = 5'd24;
    localparam logic [4:0] S_A_GO   = 5'd25;
    localparam logic [4:0] S_A_WT   = 5'd26;
    localparam logic [4:0] S_JNT    = 5'd27;
    localparam logic [4:0] S_FAIL   = 5'd28;
    localparam logic [4:0] S_DONE   = 5'd29;

    logic [4:0] r_state;
    logic [4:0] n_state;

    logic [15:0] r_lower, r_upper, r_base, r_reach, r_hoff;

    logic [16:0]        r_x;
    logic [16:0]        r_ay;
    logic               r_yneg;
    logic signed [16:0] r_z;
    logic signed [31:0] r_rot;
    logic [63:0]        r_acc;
    logic [63:0]        r_tmp;
    logic               r_xxneg;
    logic               r_zzneg;
    logic [25:0]        r_ax;
    logic [25:0]        r_az;
    logic [50:0]        r_d2;
    logic [25:0]        r_d;
    logic signed [31:0] r_phi;
    logic [31:0]        r_uu;
    logic [31:0]        r_ll;
    logic [41:0]        r_ud;
    logic [41:0]        r_ld;
    logic [30:0]        r_q1;
    logic [30:0]        r_q2;
    logic               r_n1neg;
    logic               r_n2neg;
    logic               r_phase;
    logic [30:0]        r_s;
    logic signed [31:0] r_a2;
    logic signed [31:0] r_a3;
    logic               r_ok;
    taik_pkg::t_joint   r_held [JOINT_COUNT];
    taik_pkg::t_joint   r_oj   [JOINT_COUNT];
    logic               r_ook;
    logic               r_ovalid;

    logic               w_in_acc;
    logic [31:0]        w_ma;
    logic [31:0]        w_mb;
    logic [63:0]        w_prod;
    logic               w_sqrt_start;
    logic [63:0]        w_sqrt_in;
    logic               w_sqrt_done;
    logic [31:0]        w_root;
    logic               w_cor_start;
    logic [31:0]        w_cor_x;
    logic [31:0]        w_cor_y;
    logic               w_cor_done;
    logic signed [31:0] w_ang;
    logic               w_div_start;
    logic [51:0]        w_div_num;
    logic [50:0]        w_div_den;
    logic               w_div_done;
    logic               w_div_ok;
    logic [30:0]        w_quot;
    logic [30:0]        w_qcur;
    logic               w_ncur;
    logic signed [32:0] w_diff;
    logic signed [52:0] w_num1;
    logic signed [52:0] w_num2;
    logic signed [52:0] w_numsel;
    logic signed [26:0] w_xx;
    logic signed [18:0] w_zz19;
    logic signed [26:0] w_zz;
    logic [63:0]        w_sum;
    logic signed [31:0] w_acos;
    logic signed [31:0] w_j [JOINT_COUNT];

    assign w_in_acc       = i_target.valid && i_target.ready;
    assign i_target.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= taik_pkg::RST_LOWER;
            r_upper <= taik_pkg::RST_UPPER;
            r_base  <= taik_pkg::RST_BASE;
            r_reach <= taik_pkg::RST_REACH;
            r_hoff  <= taik_pkg::RST_HOFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                taik_pkg::CFG_LOWER: r_lower <= i_cfg_data;
                taik_pkg::CFG_UPPER: r_upper <= i_cfg_data;
                taik_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                taik_pkg::CFG_REACH: r_reach <= i_cfg_data;
                taik_pkg::CFG_HOFF:  r_hoff  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (r_state)
            S_SQX:   begin w_ma = {15'd0, r_x};        w_mb = {15'd0, r_x};        end
            S_SQY:   begin w_ma = {15'd0, r_ay};       w_mb = {15'd0, r_ay};       end
            S_SQAX:  begin w_ma = {6'd0, r_ax};        w_mb = {6'd0, r_ax};        end
            S_SQAZ:  begin w_ma = {6'd0, r_az};        w_mb = {6'd0, r_az};        end
            S_UU:    begin w_ma = {16'd0, r_upper};    w_mb = {16'd0, r_upper};    end
            S_LL:    begin w_ma = {16'd0, r_lower};    w_mb = {16'd0, r_lower};    end
            S_UD:    begin w_ma = {16'd0, r_upper};    w_mb = {6'd0, r_d};         end
            S_LD:    begin w_ma = {16'd0, r_lower};    w_mb = {6'd0, r_d};         end
            S_MM:    begin w_ma = {1'b0, w_qcur};      w_mb = {1'b0, w_qcur};      end
            default: begin w_ma = 32'd0;               w_mb = 32'd0;               end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    assign w_qcur = r_phase ? r_q1 : r_q2;
    assign w_ncur = r_phase ? r_n1neg : r_n2neg;
    assign w_sum  = r_acc + r_tmp;

    assign w_sqrt_start = (r_state == S_R_GO) || (r_state == S_D_GO) || (r_state == S_S_GO);
    always_comb begin
        priority if (r_state == S_R_GO) begin
            w_sqrt_in = {w_sum[47:0], 16'd0};
        end else if (r_state == S_D_GO) begin
            w_sqrt_in = {13'd0, r_d2};
        end else begin
            w_sqrt_in = 64'h1000_0000_0000_0000 - r_acc;
        end
    end

    assign w_cor_start = (r_state == S_ROT_GO) || (r_state == S_PHI_GO) || (r_state == S_A_GO);
    always_comb begin
        priority if (r_state == S_ROT_GO) begin
            w_cor_x = {3'd0, r_x, 12'd0};
            w_cor_y = {3'd0, r_ay, 12'd0};
        end else if (r_state == S_PHI_GO) begin
            w_cor_x = {2'd0, r_ax, 4'd0};
            w_cor_y = {2'd0, r_az, 4'd0};
        end else begin
            w_cor_x = {1'b0, w_qcur};
            w_cor_y = {1'b0, r_s};
        end
    end

    assign w_diff   = $signed({1'b0, r_uu}) - $signed({1'b0, r_ll});
    assign w_num1   = $signed({2'b0, r_d2}) + $signed({{4{w_diff[32]}}, w_diff, 16'd0});
    assign w_num2   = $signed({2'b0, r_d2}) - $signed({{4{w_diff[32]}}, w_diff, 16'd0});
    assign w_numsel = (r_state == S_C1_GO) ? w_num1 : w_num2;
    assign w_div_start = (r_state == S_C1_GO) || (r_state == S_C2_GO);
    assign w_div_num   = w_numsel[52] ? 52'(-w_numsel) : w_numsel[51:0];
    assign w_div_den   = (r_state == S_C1_GO) ? {r_ud, 9'd0} : {r_ld, 9'd0};

    assign w_xx   = $signed({2'b0, w_root[24:0]}) - $signed({3'b0, r_reach, 8'd0});
    assign w_zz19 = $signed({{2{r_z[16]}}, r_z}) + $signed({3'b0, r_hoff})
                  - $signed({3'b0, r_base});
    assign w_zz   = $signed({w_zz19, 8'd0});

    assign w_acos = w_ncur ? (taik_pkg::DEG180 - w_ang) : w_ang;

    assign w_j[0] = r_rot;
    assign w_j[1] = taik_pkg::DEG90 - r_a2;
    assign w_j[2] = r_a2 + r_a3 - taik_pkg::K_176P11 + taik_pkg::DEG90;
    assign w_j[3] = r_a2 - taik_pkg::DEG90;
    assign w_j[4] = taik_pkg::DEG90 - r_a2;
    assign w_j[5] = r_a3;
    assign w_j[6] = taik_pkg::DEG90 - (r_a2 + r_a3);
    assign w_j[7] = taik_pkg::K_176P11 - taik_pkg::DEG180 - r_a3;
    assign w_j[8] = taik_pkg::K_48P39 + r_a3 - taik_pkg::K_44P55;

    taik_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (w_sqrt_in),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    taik_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_x     (w_cor_x),
        .i_y     (w_cor_y),
        .o_done  (w_cor_done),
        .o_angle (w_ang)
    );

    taik_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_ok    (w_div_ok),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_acc) n_state = S_ROT_GO;
            S_ROT_GO: n_state = S_ROT_WT;
            S_ROT_WT: if (w_cor_done) n_state = S_SQX;
            S_SQX:    n_state = S_SQY;
            S_SQY:    n_state = S_R_GO;
            S_R_GO:   n_state = S_R_WT;
            S_R_WT:   if (w_sqrt_done) n_state = S_SQAX;
            S_SQAX:   n_state = S_SQAZ;
            S_SQAZ:   n_state = S_D2;
            S_D2:     n_state = (w_sum == 64'd0) ? S_FAIL : S_D_GO;
            S_D_GO:   n_state = S_D_WT;
            S_D_WT:   if (w_sqrt_done) n_state = S_PHI_GO;
            S_PHI_GO: n_state = S_PHI_WT;
            S_PHI_WT: if (w_cor_done) n_state = S_UU;
            S_UU:     n_state = S_LL;
            S_LL:     n_state = S_UD;
            S_UD:     n_state = S_LD;
            S_LD:     n_state = S_C1_GO;
            S_C1_GO:  n_state = S_C1_WT;
            S_C1_WT:  if (w_div_done) n_state = w_div_ok ? S_C2_GO : S_FAIL;
            S_C2_GO:  n_state = S_C2_WT;
            S_C2_WT:  if (w_div_done) n_state = w_div_ok ? S_MM : S_FAIL;
            S_MM:     n_state = S_S_GO;
            S_S_GO:   n_state = S_S_WT;
            S_S_WT:   if (w_sqrt_done) n_state = S_A_GO;
            S_A_GO:   n_state = S_A_WT;
            S_A_WT:   if (w_cor_done) n_state = r_phase ? S_JNT : S_MM;
            S_JNT:    n_state = S_DONE;
            S_FAIL:   n_state = S_DONE;
            S_DONE:   if (!r_ovalid || o_joint.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ok     <= 1'b0;
            r_phase  <= 1'b0;
            for (int k = 0; k < JOINT_COUNT; k++) begin
                r_held[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_joint.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_x     <= ($signed(i_target.target_x) < 17'sd10) ? 17'd10
                                   : i_target.target_x;
                        r_ay    <= i_target.target_y[16] ? 17'(-i_target.target_y)
                                   : i_target.target_y;
                        r_yneg  <= i_target.target_y[16];
                        r_z     <= i_target.target_z;
                        r_phase <= 1'b0;
                    end
                end
                S_ROT_WT: if (w_cor_done) r_rot <= r_yneg ? -w_ang : w_ang;
                S_SQX:    r_acc <= w_prod;
                S_SQY:    r_tmp <= w_prod;
                S_R_WT: begin
                    if (w_sqrt_done) begin
                        r_xxneg <= w_xx[26];
                        r_zzneg <= w_zz[26];
                        r_ax    <= w_xx[26] ? 26'(-w_xx) : w_xx[25:0];
                        r_az    <= w_zz[26] ? 26'(-w_zz) : w_zz[25:0];
                    end
                end
                S_SQAX:   r_acc <= w_prod;
                S_SQAZ:   r_tmp <= w_prod;
                S_D2:     r_d2  <= w_sum[50:0];
                S_D_WT:   if (w_sqrt_done) r_d <= w_root[25:0];
                S_PHI_WT: if (w_cor_done) r_phi <= (r_xxneg != r_zzneg) ? -w_ang : w_ang;
                S_UU:     r_uu <= w_prod[31:0];
                S_LL:     r_ll <= w_prod[31:0];
                S_UD:     r_ud <= w_prod[41:0];
                S_LD:     r_ld <= w_prod[41:0];
                S_C1_GO:  r_n1neg <= w_num1[52];
                S_C1_WT:  if (w_div_done) r_q1 <= w_quot;
                S_C2_GO:  r_n2neg <= w_num2[52];
                S_C2_WT:  if (w_div_done) r_q2 <= w_quot;
                S_MM:     r_acc <= w_prod;
                S_S_WT:   if (w_sqrt_done) r_s <= w_root[30:0];
                S_A_WT: begin
                    if (w_cor_done) begin
                        if (r_phase) begin
                            r_a3 <= w_acos - r_phi - taik_pkg::K_3P8;
                        end else begin
                            r_a2    <= w_acos + r_phi;
                            r_phase <= 1'b1;
                        end
                    end
                end
                S_JNT: begin
                    r_ok <= 1'b1;
                    for (int k = 0; k < JOINT_COUNT; k++) begin
                        r_held[k] <= taik_pkg::to_q8(w_j[k]);
                    end
                end
                S_FAIL:   r_ok <= 1'b0;
                S_DONE: begin
                    if (!r_ovalid || o_joint.ready) begin
                        r_ovalid <= 1'b1;
                        r_ook    <= r_ok;
                        for (int k = 0; k < JOINT_COUNT; k++) begin
                            r_oj[k] <= r_held[k];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_joint.valid       = r_ovalid;
    assign o_joint.ik_ok       = r_ook;
    assign o_joint.joint_one   = r_oj[0];
    assign o_joint.joint_two   = r_oj[1];
    assign o_joint.joint_three = r_oj[2];
    assign o_joint.joint_four  = r_oj[3];
    assign o_joint.joint_five  = r_oj[4];
    assign o_joint.joint_six   = r_oj[5];
    assign o_joint.joint_seven = r_oj[6];
    assign o_joint.joint_eight = r_oj[7];
    assign o_joint.joint_nine  = r_oj[8];

    // A root arrives only while the sequencer waits for one.
    a_sqrt_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_done |-> (r_state == S_R_WT || r_state == S_D_WT || r_state == S_S_WT))
        else $error("square root finished outside a wait state");

    // An angle arrives only while the sequencer waits for one.
    a_cordic_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cor_done |-> (r_state == S_ROT_WT || r_state == S_PHI_WT || r_state == S_A_WT))
        else $error("CORDIC finished outside a wait state");

    // An accepted transaction always starts the solver.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_ROT_GO))
        else $error("accepted target did not start the solver");

    // A failed solve leaves the held joints untouched; joints one and six are checked.
    a_fail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FAIL) |=> (r_held[0] == $past(r_held[0]) && r_held[5] == $past(r_held[5])))
        else $error("held joints changed on an unreachable target");

endmodule
`default_nettype wire
